@@ sv/u2da_pkg.sv @@
// Shared types and constants for the unsigned-to-decimal ASCII converter.
// No dependencies; used by u2da_cell and unsigned_to_decimal_ascii_top.
`default_nettype none

package u2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int PORT_W     = 3;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = 5;

  localparam logic [CNT_W-1:0]   CONV_LAST = 5'd31;
  localparam logic [CNT_W-1:0]   EMIT_LAST = 5'd9;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] BCD_FIVE   = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ    = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic bit_shift;
    logic dig_shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/u2da_cell.sv @@
// One BCD digit cell of the conversion chain: clear, add-3 correct and shift in a bit,
// or take the neighbor's digit. Depends on u2da_pkg.
`default_nettype none

module u2da_cell (
  input  wire                          clk,
  input  wire u2da_pkg::cell_ctrl_t    ctrl,
  input  wire                          bit_in,
  input  wire [u2da_pkg::DIGIT_W-1:0]  dig_in,
  output logic                         bit_out,
  output logic [u2da_pkg::DIGIT_W-1:0] digit
);

  logic [u2da_pkg::DIGIT_W-1:0] digit_r;
  logic [u2da_pkg::DIGIT_W-1:0] digit_nxt;
  logic [u2da_pkg::DIGIT_W-1:0] adj;

  // correct before the shift so the doubled digit stays in BCD
  always_comb begin
    adj = (digit_r >= u2da_pkg::BCD_FIVE) ? digit_r + u2da_pkg::BCD_ADJ : digit_r;
  end

  always_comb begin
    if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.bit_shift) begin
      digit_nxt = {adj[u2da_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctrl.dig_shift) begin
      digit_nxt = dig_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign bit_out = adj[u2da_pkg::DIGIT_W-1];
  assign digit   = digit_r;

endmodule

`default_nettype wire

@@ sv/unsigned_to_decimal_ascii_top.sv @@
// Top level of the unsigned-to-decimal ASCII converter: sequencer, input
// shift register and a chain of u2da_cell digit cells. Depends on u2da_pkg.
//
// Each accepted number goes through shift-and-add-3 in a chain of ten BCD
// digit cells, one input bit per cycle, then an emission phase in which the
// digits move up the chain and leave from the top cell, one per cycle.
// Characters come out most significant first with leading zeros dropped, so
// a number's digits are emitted at the end of the emission phase and, through
// the output register, yield one strobe per digit back to back in the cycle
// after each emission, the final one flagged by out_last. busy drops in the
// last emission cycle, so the next number can already be accepted in it; the
// last strobe of one number then overlaps the first conversion cycle of the next.
// The receiver cannot stall: each character is on the out_ ports for exactly
// the one cycle in which out_valid is high.
`default_nettype none

module unsigned_to_decimal_ascii_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire [u2da_pkg::VALUE_W-1:0]  in_value,
  input  wire [u2da_pkg::PORT_W-1:0]   in_port,
  output logic                         out_valid,
  output logic [u2da_pkg::CHAR_W-1:0]  out_character,
  output logic [u2da_pkg::PORT_W-1:0]  out_port_out,
  output logic                         out_last
);

  u2da_pkg::state_t state_r, state_nxt;
  logic [u2da_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [u2da_pkg::VALUE_W-1:0] value_r;
  logic [u2da_pkg::PORT_W-1:0]  port_r;
  logic                         seen_nz_r, seen_nz_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [u2da_pkg::CHAR_W-1:0]  out_char_r;
  logic [u2da_pkg::PORT_W-1:0]  out_port_r;
  logic                         out_last_r;

  logic                         accept;
  logic                         emit_end;
  logic                         emit;
  u2da_pkg::cell_ctrl_t         ctrl;
  logic [u2da_pkg::DIGIT_W-1:0] top_digit;

  logic [u2da_pkg::NUM_DIGITS-1:0] carry;
  logic [u2da_pkg::DIGIT_W-1:0]    digits [u2da_pkg::NUM_DIGITS];

  assign emit_end = (state_r == u2da_pkg::ST_EMIT) && (cnt_r == u2da_pkg::EMIT_LAST);
  assign accept   = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      u2da_pkg::ST_IDLE: begin
        if (start) state_nxt = u2da_pkg::ST_CONV;
      end
      u2da_pkg::ST_CONV: begin
        if (cnt_r == u2da_pkg::CONV_LAST) state_nxt = u2da_pkg::ST_EMIT;
      end
      u2da_pkg::ST_EMIT: begin
        if (cnt_r == u2da_pkg::EMIT_LAST) begin
          state_nxt = start ? u2da_pkg::ST_CONV : u2da_pkg::ST_IDLE;
        end
      end
      default: state_nxt = u2da_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy           = 1'b1;
    ctrl.clr       = 1'b0;
    ctrl.bit_shift = 1'b0;
    ctrl.dig_shift = 1'b0;
    case (state_r)
      u2da_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      u2da_pkg::ST_CONV: begin
        ctrl.bit_shift = 1'b1;
      end
      u2da_pkg::ST_EMIT: begin
        busy           = !emit_end;
        ctrl.dig_shift = 1'b1;
      end
      default: busy = 1'b0;
    endcase
    ctrl.clr = start && !busy;
  end

  // counter, leading-zero tracking and output word
  assign top_digit = digits[u2da_pkg::NUM_DIGITS-1];
  assign emit = (state_r == u2da_pkg::ST_EMIT) &&
                (seen_nz_r || (top_digit != '0) || (cnt_r == u2da_pkg::EMIT_LAST));

  always_comb begin
    cnt_nxt       = cnt_r;
    seen_nz_nxt   = seen_nz_r;
    out_valid_nxt = emit;
    if (accept) begin
      cnt_nxt     = '0;
      seen_nz_nxt = 1'b0;
    end else if (state_r == u2da_pkg::ST_CONV) begin
      cnt_nxt = (cnt_r == u2da_pkg::CONV_LAST) ? '0 : cnt_r + 1'b1;
    end else if (state_r == u2da_pkg::ST_EMIT) begin
      cnt_nxt     = cnt_r + 1'b1;
      seen_nz_nxt = seen_nz_r || emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= u2da_pkg::ST_IDLE;
      cnt_r       <= '0;
      seen_nz_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seen_nz_r   <= seen_nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
      port_r  <= in_port;
    end else if (state_r == u2da_pkg::ST_CONV) begin
      value_r <= {value_r[u2da_pkg::VALUE_W-2:0], 1'b0};
    end
    if (emit) begin
      out_char_r <= u2da_pkg::ASCII_ZERO + {2'b00, top_digit};
      out_port_r <= port_r;
      out_last_r <= (cnt_r == u2da_pkg::EMIT_LAST);
    end
  end

  // digit cell chain, least significant cell first
  for (genvar i = 0; i < u2da_pkg::NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      u2da_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (value_r[u2da_pkg::VALUE_W-1]),
        .dig_in  ({u2da_pkg::DIGIT_W{1'b0}}),
        .bit_out (carry[i]),
        .digit   (digits[i])
      );
    end else begin : g_next
      u2da_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (carry[i-1]),
        .dig_in  (digits[i-1]),
        .bit_out (carry[i]),
        .digit   (digits[i])
      );
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_port_out  = out_port_r;
  assign out_last      = out_last_r;

  a_accept_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == u2da_pkg::ST_CONV) && (cnt_r == '0))
    else $error("accepted word did not start conversion");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == u2da_pkg::ST_EMIT))
    else $error("character strobed outside emission");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character after the last one");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a digit run");

  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == u2da_pkg::ST_CONV) |-> (busy && !ctrl.dig_shift))
    else $error("conversion not guarded");

endmodule

`default_nettype wire
